// ===== design/bsws_pkg.sv =====
// Shared constants, codes, types and helpers for the bounded stack with search.
package bsws_pkg;

  // Stack depth and derived widths
  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int POS_W = 3;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int OUT_DATA_W = ((WORD_W + POS_W + 7) / 8) * 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_DUMP = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // Request to the entry memory
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  // Map a stack index onto the 3-bit position field
  function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
    logic [IDX_W+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, idx};
    return ext[POS_W-1:0];
  endfunction

endpackage

// ===== design/bsws_ram.sv =====
// Entry memory of the stack: one write port, one registered read port.
module bsws_ram (
  input  logic                      clk,
  input  bsws_pkg::ram_req_t        req,
  output logic [bsws_pkg::WORD_W-1:0] rdata
);
  import bsws_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // Write the pushed word
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read one entry, hold the data between reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== design/bounded_stack_with_search.sv =====
// Top level: bounded LIFO stack with top-down linear search and full dump.
// A request is taken in S_IDLE and handled in S_EXEC, where push and the empty cases give their result;
// pop, search and dump read the top entry and reply from S_SCAN, dump with one result a cycle unless stalled.
// One request at a time: s_tready is high only in S_IDLE; search and dump are paced by the
// single read port, plus output stalls.
// Synchronous active-high reset empties the stack; entry contents are not cleared.
module bounded_stack_with_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [bsws_pkg::WORD_W-1:0]         s_tdata,  // [31:0] operand
  input  logic [bsws_pkg::OP_W-1:0]           s_tuser,  // [1:0] opcode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bsws_pkg::OUT_DATA_W-1:0]     m_tdata,  // [31:0] data_word, [34:32] position
  output logic [bsws_pkg::ST_W-1:0]           m_tuser,  // [1:0] status
  output logic                                m_tlast   // last result of the request
);
  import bsws_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]        state, state_next;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] operand;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [IDX_W-1:0]  cursor, cursor_next;
  logic [CNT_W-1:0]  fill_m1;
  logic              empty, full, out_free, match;
  logic              emit;
  logic [ST_W-1:0]   emit_status;
  logic [WORD_W-1:0] emit_word;
  logic [POS_W-1:0]  emit_pos;
  logic              emit_last;
  logic [WORD_W-1:0] rdata;
  ram_req_t          ram_req;
  logic [WORD_W-1:0] out_word;
  logic [POS_W-1:0]  out_pos;

  bsws_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign empty    = (fill == '0);
  assign full     = (fill == CNT_W'(DEPTH));
  assign fill_m1  = fill - CNT_W'(1);
  assign out_free = !m_tvalid || m_tready;
  // Single compare unit used by search, one entry per cycle
  assign match    = (rdata == operand);

  // Sequence one request
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    cursor_next   = cursor;
    emit          = 1'b0;
    emit_status   = ST_OK;
    emit_word     = operand;
    emit_pos      = '0;
    emit_last     = 1'b1;
    ram_req       = '0;
    ram_req.waddr = fill[IDX_W-1:0];
    ram_req.wdata = operand;
    ram_req.raddr = fill_m1[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op == OP_PUSH) begin
          if (out_free) begin
            emit = 1'b1;
            state_next = S_IDLE;
            if (full) begin
              emit_status = ST_FULL;
            end else begin
              emit_pos = to_pos(fill[IDX_W-1:0]);
              ram_req.we = 1'b1;
              fill_next = fill + CNT_W'(1);
            end
          end
        end else if (empty) begin
          if (out_free) begin
            emit = 1'b1;
            emit_status = ST_EMPTY;
            emit_word = (op == OP_SEARCH) ? operand : '0;
            state_next = S_IDLE;
          end
        end else begin
          // Prime the read of the top entry
          ram_req.re = 1'b1;
          cursor_next = fill_m1[IDX_W-1:0];
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_req.raddr = cursor - IDX_W'(1);
        case (op)
          OP_SEARCH: begin
            if (match || cursor == '0) begin
              if (out_free) begin
                emit = 1'b1;
                emit_status = match ? ST_OK : ST_NOT_FOUND;
                emit_pos = match ? to_pos(cursor) : '0;
                state_next = S_IDLE;
              end
            end else begin
              ram_req.re = 1'b1;
              cursor_next = cursor - IDX_W'(1);
            end
          end
          OP_DUMP: begin
            if (out_free) begin
              emit = 1'b1;
              emit_word = rdata;
              emit_pos = to_pos(cursor);
              emit_last = (cursor == '0);
              if (cursor == '0) begin
                state_next = S_IDLE;
              end else begin
                ram_req.re = 1'b1;
                cursor_next = cursor - IDX_W'(1);
              end
            end
          end
          default: begin
            // Pop: drop the top entry as it leaves
            if (out_free) begin
              emit = 1'b1;
              emit_word = rdata;
              emit_pos = to_pos(cursor);
              fill_next = CNT_W'(cursor);
              state_next = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
    end else begin
      state <= state_next;
      fill <= fill_next;
    end
  end

  // Latch the request and advance the scan cursor
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op <= s_tuser;
      operand <= s_tdata;
    end
    cursor <= cursor_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= emit_status;
      out_word <= emit_word;
      out_pos <= emit_pos;
      m_tlast <= emit_last;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - WORD_W - POS_W){1'b0}}, out_pos, out_word};

  // Stack never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) fill <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // A waiting full-status result means the stack is still full
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> full)
    else $error("full status while stack not full");

  // Only a dump gives a result that is not the last one, and it is ok
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == ST_OK && op == OP_DUMP))
    else $error("non-final result outside a dump");

  // A request moves straight into execution
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC && !s_tready))
    else $error("request not taken into execution");

endmodule
